@@ rtl/core/asia_pkg.sv @@
`default_nettype none

package asia_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned PTR_W = 8;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned RING_DEPTH_DEF = 8;
  localparam int unsigned MAX_ATTEMPTS_DEF = 5;

  // Reciprocal multipliers for division by a constant of at most 8 bits
  // never need more than 18 bits.
  localparam int unsigned RECIP_W = 18;

  localparam logic [VALUE_W-1:0] BASE_RESET = 16'd40;
  localparam logic [VALUE_W-1:0] AT_MAX_RESET = 16'd450;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_BASE = 1'b0,
    REG_AT_MAX = 1'b1
  } reg_idx_t;

  // One ring update: either a record of a mapped interval or a fill.
  typedef struct packed {
    logic rec;
    logic [VALUE_W-1:0] value;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/core/asia_regs.sv @@
`default_nettype none

module asia_regs (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [asia_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [asia_pkg::APB_DATA_W-1:0] pwdata,
  output logic [asia_pkg::APB_DATA_W-1:0] prdata,
  output logic pready,
  output logic [asia_pkg::VALUE_W-1:0] base_interval,
  output logic [asia_pkg::VALUE_W-1:0] interval_at_max
);
  import asia_pkg::*;

  logic wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_interval <= BASE_RESET;
      interval_at_max <= AT_MAX_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE: base_interval <= pwdata[VALUE_W-1:0];
        REG_AT_MAX: interval_at_max <= pwdata[VALUE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE: prdata = {{(APB_DATA_W-VALUE_W){1'b0}}, base_interval};
      REG_AT_MAX: prdata = {{(APB_DATA_W-VALUE_W){1'b0}}, interval_at_max};
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/asia_map.sv @@
`default_nettype none

module asia_map #(
  parameter int unsigned MAX_ATTEMPTS = asia_pkg::MAX_ATTEMPTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic req_type,
  input  wire logic [asia_pkg::VALUE_W-1:0] fill_value,
  input  wire logic [asia_pkg::COUNT_W-1:0] attempt_count,
  input  wire logic [asia_pkg::VALUE_W-1:0] base_interval,
  input  wire logic [asia_pkg::VALUE_W-1:0] interval_at_max,
  output logic out_valid,
  input  wire logic out_ready,
  output asia_pkg::item_t out_item
);
  import asia_pkg::*;

  // floor(x / MAX_ATTEMPTS) for any 16-bit x is (x * DivMul) >> DivShift.
  localparam int unsigned DivShift = VALUE_W + $clog2(MAX_ATTEMPTS);
  localparam longint unsigned DivMul =
    ((64'd1 << DivShift) + MAX_ATTEMPTS - 1) / MAX_ATTEMPTS;
  localparam int unsigned ProdW = VALUE_W + RECIP_W;

  logic a_valid, b_valid;
  logic take_a, take_b, take_c;

  logic a_rec;
  logic [VALUE_W-1:0] a_fill;
  logic [COUNT_W-1:0] a_count;

  logic b_rec;
  logic [VALUE_W-1:0] b_fill;
  logic [VALUE_W-1:0] b_prod;

  logic [VALUE_W-1:0] span;
  logic [VALUE_W+COUNT_W-1:0] span_mul;
  logic [ProdW-1:0] recip_mul;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] mapped;

  assign take_c = ~out_valid | out_ready;
  assign take_b = ~b_valid | take_c;
  assign take_a = ~a_valid | take_b;
  assign in_ready = take_a;

  assign span = interval_at_max - base_interval;
  assign span_mul = (VALUE_W+COUNT_W)'(span) * (VALUE_W+COUNT_W)'(a_count);

  assign recip_mul = ProdW'(b_prod) * ProdW'(DivMul);
  assign quot = VALUE_W'(recip_mul >> DivShift);
  assign mapped = quot + base_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_a) begin
        a_valid <= in_valid;
      end
      if (take_b) begin
        b_valid <= a_valid;
      end
      if (take_c) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_a && in_valid) begin
      a_rec <= req_type;
      a_fill <= fill_value;
      a_count <= attempt_count;
    end
    if (take_b && a_valid) begin
      b_rec <= a_rec;
      b_fill <= a_fill;
      b_prod <= span_mul[VALUE_W-1:0];
    end
    if (take_c && b_valid) begin
      out_item.rec <= b_rec;
      out_item.value <= b_rec ? mapped : b_fill;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/asia_ring.sv @@
`default_nettype none

module asia_ring #(
  parameter int unsigned RING_DEPTH = asia_pkg::RING_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire asia_pkg::item_t in_item,
  output logic sum_valid,
  input  wire logic sum_ready,
  output logic [asia_pkg::VALUE_W-1:0] sum
);
  import asia_pkg::*;

  localparam int unsigned SlotW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] PtrLast = '1;

  logic [VALUE_W-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] written;
  logic [VALUE_W-1:0] fill_reg;
  logic [PTR_W-1:0] write_pointer;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] slot_next;
  logic [VALUE_W-1:0] running_sum;
  logic [VALUE_W-1:0] running_sum_next;

  logic u_valid;
  item_t u_item;
  logic [SlotW-1:0] u_slot;
  logic [VALUE_W-1:0] rd_data;
  logic byp;
  logic [VALUE_W-1:0] byp_data;

  logic take_s, take_u, enter, leave_u, wr;
  logic [VALUE_W-1:0] old_entry;
  logic [VALUE_W-1:0] fill_sum;

  assign take_s = ~sum_valid | sum_ready;
  assign take_u = ~u_valid | take_s;
  assign in_ready = take_u;
  assign enter = in_valid & take_u;
  assign leave_u = u_valid & take_s;
  assign wr = leave_u & u_item.rec;

  // The slot follows write_pointer modulo the depth, including the wrap of
  // the 8-bit pointer, which restarts the slot at zero.
  always_comb begin
    if (write_pointer == PtrLast || slot == LastSlot) begin
      slot_next = '0;
    end else begin
      slot_next = slot + 1'b1;
    end
  end

  // An entry never written since the last fill holds the fill value. The
  // beat ahead may write the same slot on the edge this one reads it.
  assign old_entry = byp ? byp_data : (written[u_slot] ? rd_data : fill_reg);
  assign fill_sum = VALUE_W'(32'(u_item.value) * 32'(RING_DEPTH));

  always_comb begin
    if (u_item.rec) begin
      running_sum_next = running_sum - old_entry + u_item.value;
    end else begin
      running_sum_next = fill_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid <= 1'b0;
      sum_valid <= 1'b0;
      written <= '0;
      fill_reg <= '0;
      write_pointer <= '0;
      slot <= '0;
      running_sum <= '0;
    end else begin
      if (take_u) begin
        u_valid <= in_valid;
      end
      if (take_s) begin
        sum_valid <= u_valid;
      end
      if (enter && in_item.rec) begin
        write_pointer <= write_pointer + 1'b1;
        slot <= slot_next;
      end
      if (leave_u) begin
        running_sum <= running_sum_next;
        if (u_item.rec) begin
          written[u_slot] <= 1'b1;
        end else begin
          written <= '0;
          fill_reg <= u_item.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[u_slot] <= u_item.value;
    end
    if (enter) begin
      rd_data <= mem[slot];
      byp <= wr && (u_slot == slot);
      byp_data <= u_item.value;
      u_item <= in_item;
      u_slot <= slot;
    end
  end

  assign sum = running_sum;

endmodule

`default_nettype wire

@@ rtl/core/asia_avg.sv @@
`default_nettype none

module asia_avg #(
  parameter int unsigned RING_DEPTH = asia_pkg::RING_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic sum_valid,
  output logic sum_ready,
  input  wire logic [asia_pkg::VALUE_W-1:0] sum,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [asia_pkg::VALUE_W-1:0] sleep_interval
);
  import asia_pkg::*;

  // floor(x / RING_DEPTH) for any 16-bit x is (x * AvgMul) >> AvgShift.
  localparam int unsigned AvgShift = VALUE_W + $clog2(RING_DEPTH);
  localparam longint unsigned AvgMul =
    ((64'd1 << AvgShift) + RING_DEPTH - 1) / RING_DEPTH;
  localparam int unsigned ProdW = VALUE_W + RECIP_W;

  logic take;
  logic [ProdW-1:0] avg_mul;

  assign take = ~out_valid | out_ready;
  assign sum_ready = take;
  assign avg_mul = ProdW'(sum) * ProdW'(AvgMul);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && sum_valid) begin
      sleep_interval <= VALUE_W'(avg_mul >> AvgShift);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/adaptive_sleep_interval_average.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_ready    req_type, fill_value, attempt_count
// output    out_valid / out_ready  sleep_interval
// config    APB write/read         base_interval (0x0), interval_at_max (0x4)
//
// One item per clock unless out_ready stalls; beats pass map, ring, then average.
// The single ring update stage, which reads and writes the ring once per
// cycle, sets the rate; the mapping multiplies sit in two stages ahead of it.
// Synchronous reset empties the pipeline and makes every ring entry read as
// zero at once through per-entry written flags; no clearing pass is needed.
// Every stage loads when it is empty or its contents move on, so bubbles
// close up; input beats are still taken into empty stages while a result waits.
`default_nettype none

module adaptive_sleep_interval_average #(
  parameter int unsigned RING_DEPTH = asia_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_ATTEMPTS = asia_pkg::MAX_ATTEMPTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [asia_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [asia_pkg::APB_DATA_W-1:0] pwdata,
  output logic [asia_pkg::APB_DATA_W-1:0] prdata,
  output logic pready,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic req_type,
  input  wire logic [asia_pkg::VALUE_W-1:0] fill_value,
  input  wire logic [asia_pkg::COUNT_W-1:0] attempt_count,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [asia_pkg::VALUE_W-1:0] sleep_interval
);
  import asia_pkg::*;

  logic [VALUE_W-1:0] base_interval;
  logic [VALUE_W-1:0] interval_at_max;

  logic map_valid, map_ready;
  item_t map_item;

  logic sum_valid, sum_ready;
  logic [VALUE_W-1:0] sum;

  asia_regs u_regs (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .base_interval(base_interval),
    .interval_at_max(interval_at_max)
  );

  asia_map #(
    .MAX_ATTEMPTS(MAX_ATTEMPTS)
  ) u_map (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .fill_value(fill_value),
    .attempt_count(attempt_count),
    .base_interval(base_interval),
    .interval_at_max(interval_at_max),
    .out_valid(map_valid),
    .out_ready(map_ready),
    .out_item(map_item)
  );

  asia_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk(clk),
    .rst(rst),
    .in_valid(map_valid),
    .in_ready(map_ready),
    .in_item(map_item),
    .sum_valid(sum_valid),
    .sum_ready(sum_ready),
    .sum(sum)
  );

  asia_avg #(
    .RING_DEPTH(RING_DEPTH)
  ) u_avg (
    .clk(clk),
    .rst(rst),
    .sum_valid(sum_valid),
    .sum_ready(sum_ready),
    .sum(sum),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sleep_interval(sleep_interval)
  );

  // A free output register must free every stage behind it in the same cycle.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled although the output register can load");

  // The running sum is the held beat of the ring stage and must not move.
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && !sum_ready) |=> (sum_valid && $stable(sum)))
    else $error("running sum changed while its beat was stalled");

  a_map_hold: assert property (@(posedge clk) disable iff (rst)
    (map_valid && !map_ready) |=> (map_valid && $stable(map_item)))
    else $error("mapped item changed while stalled before the ring");

endmodule

`default_nettype wire
